FILE: rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants of the csv stream tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int unsigned MAXRES  = 5;
  localparam logic [9:0]  COL_MAX = 10'd1023;

  // input word modes
  typedef enum logic [1:0] {
    MODE_BYTE    = 2'd0,
    MODE_END     = 2'd1,
    MODE_RESTART = 2'd2
  } mode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DELIM      = 2'd0,
    CFG_READ_TITLE = 2'd1,
    CFG_SKIP_EMPTY = 2'd2
  } cfg_e;

  typedef enum logic [3:0] {
    EV_ROW_BEGIN    = 4'd0,
    EV_FIELD_BEGIN  = 4'd1,
    EV_FIELD_CHAR   = 4'd2,
    EV_FIELD_NULL   = 4'd3,
    EV_FIELD_VALUE  = 4'd4,
    EV_FIELD_ABSENT = 4'd5,
    EV_ROW_END      = 4'd6,
    EV_TITLE_CHAR   = 4'd7,
    EV_TITLE_END    = 4'd8,
    EV_QUOTE_PREFIX = 4'd9,
    EV_ERROR        = 4'd10
  } event_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_COLS  = 2'd1,
    ERR_TITLE = 2'd2,
    ERR_AUTO  = 2'd3
  } err_e;

  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SQ      = 8'h27;
  localparam logic [7:0] CH_DQ      = 8'h22;
  localparam logic [7:0] CH_US      = 8'h5F;
  localparam logic [7:0] CH_SP      = 8'h20;
  localparam logic [7:0] DELIM_AUTO = 8'h00;
  localparam logic [7:0] DELIM_RST  = 8'h2C;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] text_byte;
  } in_t;

  typedef struct packed {
    event_e      event_kind;
    logic [9:0]  column_index;
    logic [7:0]  char_out;
    logic [31:0] line_count;
    err_e        error_code;
    logic        last_of_run;
  } out_t;

endpackage

FILE: rtl/csv_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_stream_tokenizer
// Byte-wise CSV parser producing row, field, title and error words.
// ----------------------------------------------------------------------------
// One input word is parsed per cycle while in_ready_o is high, in a single
// combinational pass over the parser state and the word; the up to four result
// words it causes are loaded into a five-entry burst register that drains one
// word per cycle while out_ready_i is high. Most bytes give one word and stream
// at one per cycle when the output does not stall, a new input being taken in
// the cycle the last word of the previous burst is taken. Delimiter and title
// writes take effect at the next restart word; skip-empty is used directly.
module csv_stream_tokenizer
  import cst_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int unsigned CW = $clog2(MAX_COLUMNS);
  localparam int unsigned TW = $clog2(MAX_COLUMNS + 1);

  typedef enum logic [3:0] {
    ST_DETECT, ST_DETECT_Q, ST_DETECT_P, ST_TITLE, ST_QTITLE, ST_QTITLEP,
    ST_CR, ST_ROWSTART, ST_DATASTART, ST_DATA0, ST_DATA, ST_QDATA, ST_QDATA_END
  } state_e;

  typedef struct packed {
    event_e     kind;
    logic [9:0] col;
    logic [7:0] ch;
  } ev_t;

  function automatic logic [9:0] clamp_col(input logic [TW-1:0] v);
    logic [16:0] w;
    w = 17'(v);
    return (w > 17'(COL_MAX)) ? COL_MAX : w[9:0];
  endfunction

  function automatic ev_t mk_ev(input event_e k, input logic [9:0] col,
                                input logic [7:0] ch);
    ev_t e;
    e.kind = k;
    e.col  = col;
    e.ch   = ch;
    return e;
  endfunction

  function automatic logic is_nl(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return (c == CH_SQ) || (c == CH_DQ);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
           (c == CH_US) || (c == CH_SP);
  endfunction

  // configuration
  logic [7:0] delim_q;
  logic       title_q, skip_q;

  // parser state
  state_e      st_q, st_d;
  logic [7:0]  adel_q, adel_d, oq_q, oq_d;
  logic [CW-1:0] cur_q, cur_d;
  logic [TW-1:0] expc_q, expc_d, tcnt_q, tcnt_d;
  logic [31:0] nlc_q, nlc_d;
  logic        vne_q, vne_d, tne_q, tne_d, errl_q, errl_d;

  // burst register
  ev_t        ev_q [MAXRES];
  ev_t        evs  [MAXRES];
  logic [2:0] cnt_q, idx_q, k;
  logic [31:0] lc_q;
  err_e       errc_q, errc_d;

  logic [7:0]    c;
  logic [TW-1:0] ncols;
  logic          close_req, do_rs, do_ds, do_dt, ok;
  logic          in_acc, out_acc;

  assign in_ready_o  = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign c           = in_data_i.text_byte;

  always_comb begin
    st_d = st_q; adel_d = adel_q; oq_d = oq_q; cur_d = cur_q;
    expc_d = expc_q; tcnt_d = tcnt_q; nlc_d = nlc_q;
    vne_d = vne_q; tne_d = tne_q; errl_d = errl_q;
    errc_d = ERR_NONE;
    k = 3'd0;
    close_req = 1'b0; do_rs = 1'b0; do_ds = 1'b0; do_dt = 1'b0;
    ok = 1'b1; ncols = '0;
    for (int i = 0; i < MAXRES; i++) evs[i] = mk_ev(EV_ROW_BEGIN, '0, '0);

    if (in_data_i.mode == MODE_RESTART) begin
      if (title_q) begin
        st_d = (delim_q == DELIM_AUTO) ? ST_DETECT : ST_TITLE;
      end else begin
        st_d = ST_ROWSTART;
      end
      adel_d = delim_q; oq_d = '0; cur_d = '0; expc_d = '0;
      tcnt_d = TW'(1); nlc_d = '0; vne_d = 1'b0; tne_d = 1'b0; errl_d = 1'b0;
      if ((delim_q == DELIM_AUTO) && !title_q) begin
        evs[k] = mk_ev(EV_ERROR, '0, '0); k = k + 3'd1;
        errl_d = 1'b1; errc_d = ERR_AUTO;
      end
    end else if ((in_data_i.mode == MODE_BYTE) && !errl_q) begin
      if ((c == CH_LF) && (nlc_d != '1)) nlc_d = nlc_d + 32'd1;
      case (st_q)
        ST_DETECT, ST_DETECT_P: begin
          if (st_q == ST_DETECT && is_word(c)) begin
            evs[k] = mk_ev(EV_TITLE_CHAR, clamp_col(tcnt_d - TW'(1)), c);
            k = k + 3'd1; tne_d = 1'b1;
          end else if (st_q == ST_DETECT_P && (is_word(c) || is_quote(c))) begin
            evs[k] = mk_ev(EV_ERROR, clamp_col(TW'(cur_d)), '0); k = k + 3'd1;
            errl_d = 1'b1; errc_d = ERR_TITLE;
          end else if (is_nl(c)) begin
            evs[k] = mk_ev(EV_TITLE_END, clamp_col(tcnt_d - TW'(1)), '0);
            k = k + 3'd1; tne_d = 1'b0;
            expc_d = TW'(1);
            st_d = (c == CH_CR) ? ST_CR : ST_ROWSTART;
          end else if (st_q == ST_DETECT && is_quote(c)) begin
            oq_d = c; st_d = ST_DETECT_Q;
          end else begin
            adel_d = c;
            evs[k] = mk_ev(EV_TITLE_END, clamp_col(tcnt_d - TW'(1)), '0);
            k = k + 3'd1; tne_d = 1'b0;
            if (tcnt_d < TW'(MAX_COLUMNS)) tcnt_d = tcnt_d + TW'(1);
            st_d = ST_TITLE;
          end
        end
        ST_DETECT_Q, ST_QTITLE: begin
          if (c == oq_d) begin
            st_d = (st_q == ST_DETECT_Q) ? ST_DETECT_P : ST_QTITLEP;
          end else begin
            evs[k] = mk_ev(EV_TITLE_CHAR, clamp_col(tcnt_d - TW'(1)), c);
            k = k + 3'd1; tne_d = 1'b1;
          end
        end
        ST_TITLE, ST_QTITLEP: begin
          if (is_nl(c)) begin
            evs[k] = mk_ev(EV_TITLE_END, clamp_col(tcnt_d - TW'(1)), '0);
            k = k + 3'd1; tne_d = 1'b0;
            expc_d = tcnt_d;
            st_d = (c == CH_CR) ? ST_CR : ST_ROWSTART;
          end else if (c == adel_d) begin
            evs[k] = mk_ev(EV_TITLE_END, clamp_col(tcnt_d - TW'(1)), '0);
            k = k + 3'd1; tne_d = 1'b0;
            if (tcnt_d < TW'(MAX_COLUMNS)) tcnt_d = tcnt_d + TW'(1);
            st_d = ST_TITLE;
          end else if ((st_q == ST_QTITLEP) || (is_quote(c) && tne_d)) begin
            evs[k] = mk_ev(EV_ERROR, clamp_col(TW'(cur_d)), '0); k = k + 3'd1;
            errl_d = 1'b1; errc_d = ERR_TITLE;
          end else if (is_quote(c)) begin
            oq_d = c; st_d = ST_QTITLE;
          end else begin
            evs[k] = mk_ev(EV_TITLE_CHAR, clamp_col(tcnt_d - TW'(1)), c);
            k = k + 3'd1; tne_d = 1'b1;
          end
        end
        ST_CR: begin
          st_d = ST_ROWSTART;
          if (c != CH_LF) do_rs = 1'b1;
        end
        ST_ROWSTART:  do_rs = 1'b1;
        ST_DATASTART: do_ds = 1'b1;
        ST_DATA0: begin
          if (is_quote(c)) begin
            oq_d = c; vne_d = 1'b0; st_d = ST_QDATA;
          end else begin
            st_d = ST_DATA; do_dt = 1'b1;
          end
        end
        ST_DATA: do_dt = 1'b1;
        ST_QDATA: begin
          if (c == oq_d) begin
            st_d = ST_QDATA_END;
          end else begin
            evs[k] = mk_ev(EV_FIELD_CHAR, clamp_col(TW'(cur_d)), c);
            k = k + 3'd1; vne_d = 1'b1;
          end
        end
        ST_QDATA_END: begin
          if (c == oq_d) begin
            evs[k] = mk_ev(EV_FIELD_CHAR, clamp_col(TW'(cur_d)), c);
            k = k + 3'd1; vne_d = 1'b1;
            st_d = ST_QDATA;
          end else if (is_nl(c) || (c == adel_d)) begin
            evs[k] = mk_ev(vne_d ? EV_FIELD_VALUE : EV_FIELD_NULL,
                           clamp_col(TW'(cur_d)), '0);
            k = k + 3'd1; vne_d = 1'b0;
            if (is_nl(c)) begin
              close_req = 1'b1;
            end else begin
              if (cur_d < CW'(MAX_COLUMNS - 1)) cur_d = cur_d + CW'(1);
              evs[k] = mk_ev(EV_FIELD_BEGIN, clamp_col(TW'(cur_d)), '0);
              k = k + 3'd1; st_d = ST_DATA0;
            end
          end else begin
            evs[k] = mk_ev(EV_QUOTE_PREFIX, clamp_col(TW'(cur_d)), oq_d);
            k = k + 3'd1;
            evs[k] = mk_ev(EV_FIELD_CHAR, clamp_col(TW'(cur_d)), c);
            k = k + 3'd1; vne_d = 1'b1;
            st_d = ST_DATA;
          end
        end
        default: st_d = ST_ROWSTART;
      endcase

      // row start
      if (do_rs) begin
        cur_d = '0;
        if (skip_q && is_nl(c)) begin
          st_d = (c == CH_CR) ? ST_CR : ST_ROWSTART;
        end else begin
          evs[k] = mk_ev(EV_ROW_BEGIN, '0, '0); k = k + 3'd1;
          do_ds = 1'b1;
        end
      end

      // field start
      if (do_ds) begin
        st_d = ST_DATASTART;
        evs[k] = mk_ev(EV_FIELD_BEGIN, clamp_col(TW'(cur_d)), '0); k = k + 3'd1;
        if (is_nl(c)) begin
          evs[k] = mk_ev(EV_FIELD_ABSENT, clamp_col(TW'(cur_d)), '0);
          k = k + 3'd1; close_req = 1'b1;
        end else if (is_quote(c)) begin
          oq_d = c; vne_d = 1'b0; st_d = ST_QDATA;
        end else if (c == adel_d) begin
          evs[k] = mk_ev(EV_FIELD_ABSENT, clamp_col(TW'(cur_d)), '0);
          k = k + 3'd1;
          if (cur_d < CW'(MAX_COLUMNS - 1)) cur_d = cur_d + CW'(1);
        end else begin
          evs[k] = mk_ev(EV_FIELD_CHAR, clamp_col(TW'(cur_d)), c);
          k = k + 3'd1; vne_d = 1'b1; st_d = ST_DATA;
        end
      end

      // unquoted field byte
      if (do_dt) begin
        if (is_nl(c) || (c == adel_d)) begin
          evs[k] = mk_ev(vne_d ? EV_FIELD_VALUE : EV_FIELD_NULL,
                         clamp_col(TW'(cur_d)), '0);
          k = k + 3'd1; vne_d = 1'b0;
          if (is_nl(c)) begin
            close_req = 1'b1;
          end else begin
            if (cur_d < CW'(MAX_COLUMNS - 1)) cur_d = cur_d + CW'(1);
            evs[k] = mk_ev(EV_FIELD_BEGIN, clamp_col(TW'(cur_d)), '0);
            k = k + 3'd1; st_d = ST_DATA0;
          end
        end else begin
          evs[k] = mk_ev(EV_FIELD_CHAR, clamp_col(TW'(cur_d)), c);
          k = k + 3'd1; vne_d = 1'b1;
        end
      end

      // row close with column check
      if (close_req) begin
        ncols = TW'(cur_d) + TW'(1);
        if (expc_d == '0) begin
          expc_d = ncols;
        end else begin
          ok = (ncols == expc_d);
        end
        if (!ok) begin
          evs[k] = mk_ev(EV_ERROR, clamp_col(TW'(cur_d)), '0); k = k + 3'd1;
          errl_d = 1'b1; errc_d = ERR_COLS;
        end else begin
          evs[k] = mk_ev(EV_ROW_END, clamp_col(TW'(cur_d)), '0); k = k + 3'd1;
          st_d = (c == CH_CR) ? ST_CR : ST_ROWSTART;
        end
      end
    end else if ((in_data_i.mode == MODE_END) && !errl_q) begin
      case (st_q)
        ST_DATASTART: begin
          evs[k] = mk_ev(EV_ROW_END, clamp_col(TW'(cur_d)), '0); k = k + 3'd1;
          st_d = ST_ROWSTART;
        end
        ST_DATA0, ST_DATA, ST_QDATA, ST_QDATA_END: begin
          if (st_q == ST_QDATA_END) begin
            evs[k] = mk_ev(vne_d ? EV_FIELD_VALUE : EV_FIELD_NULL,
                           clamp_col(TW'(cur_d)), '0);
            k = k + 3'd1; vne_d = 1'b0;
          end
          ncols = TW'(cur_d) + TW'(1);
          if (expc_d == '0) begin
            expc_d = ncols;
          end else begin
            ok = (ncols == expc_d);
          end
          if (!ok) begin
            evs[k] = mk_ev(EV_ERROR, clamp_col(TW'(cur_d)), '0); k = k + 3'd1;
            errl_d = 1'b1; errc_d = ERR_COLS;
          end else begin
            if (st_q != ST_QDATA_END) begin
              evs[k] = mk_ev(vne_d ? EV_FIELD_VALUE : EV_FIELD_NULL,
                             clamp_col(TW'(cur_d)), '0);
              k = k + 3'd1; vne_d = 1'b0;
            end
            evs[k] = mk_ev(EV_ROW_END, clamp_col(TW'(cur_d)), '0); k = k + 3'd1;
            st_d = ST_ROWSTART;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RST;
      title_q <= 1'b1;
      skip_q  <= 1'b0;
      st_q    <= ST_TITLE;
      adel_q  <= DELIM_RST;
      oq_q    <= '0;
      cur_q   <= '0;
      expc_q  <= '0;
      tcnt_q  <= TW'(1);
      nlc_q   <= '0;
      vne_q   <= 1'b0;
      tne_q   <= 1'b0;
      errl_q  <= 1'b0;
      for (int i = 0; i < MAXRES; i++) ev_q[i] <= mk_ev(EV_ROW_BEGIN, '0, '0);
      cnt_q   <= '0;
      idx_q   <= '0;
      lc_q    <= '0;
      errc_q  <= ERR_NONE;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DELIM:      delim_q <= cfg_wdata_i;
          CFG_READ_TITLE: title_q <= cfg_wdata_i[0];
          CFG_SKIP_EMPTY: skip_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        st_q   <= st_d;
        adel_q <= adel_d;
        oq_q   <= oq_d;
        cur_q  <= cur_d;
        expc_q <= expc_d;
        tcnt_q <= tcnt_d;
        nlc_q  <= nlc_d;
        vne_q  <= vne_d;
        tne_q  <= tne_d;
        errl_q <= errl_d;
        ev_q   <= evs;
        cnt_q  <= k;
        idx_q  <= '0;
        lc_q   <= nlc_d;
        errc_q <= errc_d;
      end else if (out_acc) begin
        cnt_q <= cnt_q - 3'd1;
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_comb begin
    out_data_o.event_kind   = ev_q[idx_q].kind;
    out_data_o.column_index = ev_q[idx_q].col;
    out_data_o.char_out     = ev_q[idx_q].ch;
    out_data_o.line_count   = lc_q;
    out_data_o.error_code   = (ev_q[idx_q].kind == EV_ERROR) ? errc_q : ERR_NONE;
    out_data_o.last_of_run  = (cnt_q == 3'd1);
  end

endmodule

FILE: rtl/cst_checker.sv
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks of the csv stream tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module cst_checker
  import cst_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input out_t       out_data_o
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // no new input while a stalled result waits
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken over a stalled result");

  // a run continues until its last word
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_of_run |=> out_valid_o)
    else $error("run ended without last word");

  // words of one run share the line count
  a_run_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_of_run |=>
      out_data_o.line_count == $past(out_data_o.line_count))
    else $error("line count changed inside a run");

  // error code only on error words
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_data_o.event_kind == EV_ERROR) == (out_data_o.error_code != ERR_NONE)))
    else $error("error code does not match word kind");

endmodule

bind csv_stream_tokenizer cst_checker u_cst_checker (.*);
